// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the scheduler modules.
// ----------------------------------------------------------------------------
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication or expression, checked outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/lifo_sched_pkg.sv
// ----------------------------------------------------------------------------
// LIFO scheduler package
// Request and result types, stack entry layout, status codes and the
// controller state encoding.
// ----------------------------------------------------------------------------
package lifo_sched_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int ENTRY_W         = 64;

  typedef struct packed {
    logic [15:0] job_id;
    logic [31:0] arrival_time;
    logic [15:0] burst_length;
    logic        final_job;
  } in_t;

  typedef struct packed {
    logic [15:0] done_id;
    logic [31:0] completion_time;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic [47:0] sum_turnaround;
    logic [47:0] sum_waiting;
    logic        status;
    logic        last_result;
  } out_t;

  // One stacked job.
  typedef struct packed {
    logic [15:0] burst;
    logic [31:0] arrival;
    logic [15:0] id;
  } job_entry_t;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_DROP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DROP,
    ST_DRAIN_CHK,
    ST_POP_RD,
    ST_POP_COMP,
    ST_POP_TAT,
    ST_POP_SUM
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic push;
    logic jump;
    logic pop_rd;
    logic pop_comp;
    logic pop_tat;
    logic pop_sum;
    logic drop;
    logic clear;
    logic last;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic time_lt_at;
    logic fin;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/lifo_sched_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lifo_sched_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/lifo_sched_dp.sv
// ----------------------------------------------------------------------------
// LIFO scheduler datapath
// Job stack, current time, batch totals, per-run arithmetic and the result
// register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lifo_sched_dp import lifo_sched_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  in_t  in_data,
  input  cmd_t cmd,
  output sts_t sts,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  in_t         job_r;
  logic [CW-1:0] cnt_r, cnt_nxt, cnt_m1;
  logic [31:0] time_r, time_nxt;
  logic [47:0] tot_tat_r, tot_tat_nxt;
  logic [47:0] tot_wt_r, tot_wt_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;

  logic [31:0] comp_r, comp_nxt;
  logic [32:0] atbt_r, atbt_nxt;
  logic [31:0] tat_r, tat_nxt;
  logic [31:0] wt_r, wt_nxt;

  logic [ENTRY_W-1:0] rdata;
  job_entry_t         wentry, top;
  logic [32:0]        time_sum;
  logic [48:0]        sum_tat, sum_wt;
  logic [47:0]        sat_tat, sat_wt;
  logic               load;

  assign cnt_m1 = cnt_r - CW'(1);
  assign wentry = '{burst: job_r.burst_length, arrival: job_r.arrival_time, id: job_r.job_id};
  assign top    = job_entry_t'(rdata);

  lifo_sched_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (cnt_r[AW-1:0]),
    .wdata (wentry),
    .re    (cmd.pop_rd),
    .raddr (cnt_m1[AW-1:0]),
    .rdata (rdata)
  );

  // Completion saturates at the top of the 32-bit time range.
  always_comb begin
    time_sum = {1'b0, time_r} + {17'b0, top.burst};
    comp_nxt = time_sum[32] ? '1 : time_sum[31:0];
    atbt_nxt = {1'b0, top.arrival} + {17'b0, top.burst};
  end

  // Waiting is compared against arrival plus burst so both values come from
  // one subtract each and run side by side.
  always_comb begin
    tat_nxt = (comp_r >= top.arrival) ? (comp_r - top.arrival) : '0;
    wt_nxt  = ({1'b0, comp_r} >= atbt_r) ? (comp_r - atbt_r[31:0]) : '0;
  end

  always_comb begin
    sum_tat = {1'b0, tot_tat_r} + {17'b0, tat_r};
    sum_wt  = {1'b0, tot_wt_r} + {17'b0, wt_r};
    sat_tat = sum_tat[48] ? '1 : sum_tat[47:0];
    sat_wt  = sum_wt[48] ? '1 : sum_wt[47:0];
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    time_nxt    = time_r;
    tot_tat_nxt = tot_tat_r;
    tot_wt_nxt  = tot_wt_r;
    if (cmd.push) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.pop_rd) begin
      cnt_nxt = cnt_m1;
    end
    if (cmd.jump) begin
      time_nxt = job_r.arrival_time;
    end else if (cmd.pop_tat) begin
      time_nxt = comp_r;
    end else if (cmd.clear) begin
      time_nxt = '0;
    end
    if (cmd.pop_sum) begin
      tot_tat_nxt = sat_tat;
      tot_wt_nxt  = sat_wt;
    end else if (cmd.clear) begin
      tot_tat_nxt = '0;
      tot_wt_nxt  = '0;
    end
  end

  assign load = cmd.pop_sum | cmd.drop;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.drop) begin
      out_data_nxt = '{done_id: job_r.job_id, completion_time: '0, turnaround: '0,
                       waiting: '0, sum_turnaround: tot_tat_r, sum_waiting: tot_wt_r,
                       status: STATUS_DROP, last_result: cmd.last};
    end else begin
      out_data_nxt = '{done_id: top.id, completion_time: time_r, turnaround: tat_r,
                       waiting: wt_r, sum_turnaround: sat_tat, sum_waiting: sat_wt,
                       status: STATUS_DONE, last_result: cmd.last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      time_r      <= '0;
      tot_tat_r   <= '0;
      tot_wt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      time_r      <= time_nxt;
      tot_tat_r   <= tot_tat_nxt;
      tot_wt_r    <= tot_wt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      job_r <= in_data;
    end
    if (cmd.pop_comp) begin
      comp_r <= comp_nxt;
      atbt_r <= atbt_nxt;
    end
    if (cmd.pop_tat) begin
      tat_r <= tat_nxt;
      wt_r  <= wt_nxt;
    end
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign sts.cnt_zero   = (cnt_r == '0);
  assign sts.cnt_full   = (cnt_r == CW'(STACK_DEPTH));
  assign sts.time_lt_at = (time_r < job_r.arrival_time);
  assign sts.fin        = job_r.final_job;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEVER(a_cnt_bound, cnt_r > CW'(STACK_DEPTH), "stack count beyond depth")
  `ASSERT_CLK(a_clear_totals, cmd.clear |=> (tot_tat_r == '0 && tot_wt_r == '0 && time_r == '0), "batch clear failed")

endmodule

// File: rtl/core/lifo_sched_ctrl.sv
// ----------------------------------------------------------------------------
// LIFO scheduler controller
// Sequences accept, pop/run, push, drop and final drain of each request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lifo_sched_ctrl import lifo_sched_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   drain_r, drain_nxt;
  logic   pop_more;

  // Keep running stacked jobs while time is still behind the new arrival.
  assign pop_more = !sts.cnt_zero && sts.time_lt_at;

  always_comb begin
    state_nxt = state_r;
    drain_nxt = drain_r;
    case (state_r)
      ST_IDLE: begin
        drain_nxt = 1'b0;
        if (in_valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (pop_more) begin
          state_nxt = ST_POP_RD;
        end else if (sts.cnt_full) begin
          state_nxt = ST_DROP;
        end else if (sts.fin) begin
          state_nxt = ST_DRAIN_CHK;
          drain_nxt = 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DROP: begin
        if (sts.out_free) begin
          state_nxt = sts.fin ? ST_DRAIN_CHK : ST_IDLE;
          drain_nxt = sts.fin;
        end
      end
      ST_DRAIN_CHK: begin
        if (sts.cnt_zero) begin
          state_nxt = ST_IDLE;
          drain_nxt = 1'b0;
        end else begin
          state_nxt = ST_POP_RD;
        end
      end
      ST_POP_RD:   state_nxt = ST_POP_COMP;
      ST_POP_COMP: state_nxt = ST_POP_TAT;
      ST_POP_TAT:  state_nxt = ST_POP_SUM;
      ST_POP_SUM: begin
        if (sts.out_free) begin
          state_nxt = drain_r ? ST_DRAIN_CHK : ST_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_CHECK: begin
        cmd.jump = sts.cnt_zero && sts.time_lt_at;
        cmd.push = !pop_more && !sts.cnt_full;
      end
      ST_DROP: begin
        cmd.drop = sts.out_free;
        cmd.last = !sts.fin;
      end
      ST_DRAIN_CHK: begin
        cmd.clear = sts.cnt_zero;
      end
      ST_POP_RD:   cmd.pop_rd   = 1'b1;
      ST_POP_COMP: cmd.pop_comp = 1'b1;
      ST_POP_TAT:  cmd.pop_tat  = 1'b1;
      ST_POP_SUM: begin
        cmd.pop_sum = sts.out_free;
        // Time already holds this run's completion here.
        cmd.last    = drain_r ? sts.cnt_zero : (!sts.fin && !pop_more);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
    end
  end

  `ASSERT_CLK(a_pop_nonempty, cmd.pop_rd |-> !sts.cnt_zero, "pop from empty stack")
  `ASSERT_CLK(a_push_room, cmd.push |-> !sts.cnt_full, "push into full stack")
  `ASSERT_CLK(a_emit_free, (cmd.pop_sum || cmd.drop) |-> sts.out_free, "result register overwritten")

endmodule

// File: rtl/core/lifo_nonpreemptive_scheduler.sv
// ----------------------------------------------------------------------------
// LIFO non-preemptive job scheduler
// Requests carry a job (id, arrival, burst, final mark) in arrival order.
// Before a job is pushed, stacked jobs are popped and run, newest first,
// while the current time is below its arrival; an empty stack makes time
// jump to the arrival. Each run gives one result with completion,
// turnaround, waiting and the running batch totals. A push to a full stack
// gives a dropped result instead. A final-marked job drains the stack and
// then clears time and totals. The last result of a request is marked.
// Sequence: a request is taken in the idle state and checked/pushed in the
// check state that follows. Every job run steps through a stack read,
// completion add, turnaround/waiting subtract and total add, then a
// recheck of stack and time; a drop and a final drain check each add a
// state of their own.
// The next request is taken once the previous one has issued its last
// result into the output register.
// Reset empties the stack and clears time and totals. A stalled receiver
// holds the result register; the block waits to issue the next result.
// ----------------------------------------------------------------------------
module lifo_nonpreemptive_scheduler import lifo_sched_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t cmd;
  sts_t sts;

  lifo_sched_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lifo_sched_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: verif/lifo_nonpreemptive_scheduler_tb.sv
// ----------------------------------------------------------------------------
// LIFO non-preemptive scheduler testbench
// Sends jobs as requests through the valid/ready input, predicts every run
// and drop with a cycle-free copy of the scheduling rules, and checks each
// result field by field in prediction order. Covers extremes, full stack,
// saturated time, a long output stall, a gap-free stretch and random batches.
// ----------------------------------------------------------------------------
module lifo_nonpreemptive_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lifo_sched_pkg::*;

  localparam int          DEPTH        = STACK_DEPTH_DEF;
  localparam int          IDLE_PCT     = 12;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          RANDOM_JOBS  = 240;
  localparam int          NO_IDLE_JOBS = 40;
  localparam logic [31:0] TIME_MAX     = 32'hFFFF_FFFF;
  localparam logic [47:0] TOTAL_MAX    = 48'hFFFF_FFFF_FFFF;

  typedef enum int unsigned {
    MIX_CONGESTED,
    MIX_LIGHT,
    MIX_WIDE,
    MIX_BURSTY
  } traffic_mix_e;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  lifo_nonpreemptive_scheduler #(.STACK_DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Scheduler state as the block should hold it.
  job_entry_t  sched_stack [DEPTH];
  int unsigned sched_count = 0;
  logic [31:0] sched_time = '0;
  logic [47:0] sched_sum_tat = '0;
  logic [47:0] sched_sum_wait = '0;
  out_t        due_results [$];

  logic        no_idle = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned jobs_sent = 0;
  int unsigned batches_sent = 0;
  int unsigned results_seen = 0;
  int unsigned drops_seen = 0;
  int unsigned mismatches = 0;
  int unsigned stuck_cycles = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? TOTAL_MAX : s[47:0];
  endfunction

  // Pops the newest job and runs it to completion from the current time.
  function automatic out_t run_top_job();
    job_entry_t  e;
    logic [32:0] done_at;
    out_t        r;
    sched_count--;
    e = sched_stack[sched_count];
    done_at = {1'b0, sched_time} + {17'd0, e.burst};
    r = '0;
    r.done_id = e.id;
    r.completion_time = done_at[32] ? TIME_MAX : done_at[31:0];
    r.turnaround = (r.completion_time >= e.arrival) ? r.completion_time - e.arrival : '0;
    // Only a capped completion can leave the turnaround below the burst.
    r.waiting = (r.turnaround >= {16'd0, e.burst}) ? r.turnaround - {16'd0, e.burst} : '0;
    sched_sum_tat = add_sat48(sched_sum_tat, {16'd0, r.turnaround});
    sched_sum_wait = add_sat48(sched_sum_wait, {16'd0, r.waiting});
    sched_time = r.completion_time;
    r.sum_turnaround = sched_sum_tat;
    r.sum_waiting = sched_sum_wait;
    r.status = STATUS_DONE;
    return r;
  endfunction

  function automatic void schedule_job(in_t job);
    out_t       runs [$];
    out_t       r;
    job_entry_t e;
    while (sched_count > 0 && sched_time < job.arrival_time) runs.push_back(run_top_job());
    if (sched_count == 0 && sched_time < job.arrival_time) sched_time = job.arrival_time;
    if (sched_count >= DEPTH) begin
      r = '0;
      r.done_id = job.job_id;
      r.sum_turnaround = sched_sum_tat;
      r.sum_waiting = sched_sum_wait;
      r.status = STATUS_DROP;
      runs.push_back(r);
    end else begin
      e.id = job.job_id;
      e.arrival = job.arrival_time;
      e.burst = job.burst_length;
      sched_stack[sched_count] = e;
      sched_count++;
    end
    if (job.final_job) begin
      while (sched_count > 0) runs.push_back(run_top_job());
      sched_time = '0;
      sched_sum_tat = '0;
      sched_sum_wait = '0;
    end
    if (runs.size() > 0) begin
      r = runs.pop_back();
      r.last_result = 1'b1;
      runs.push_back(r);
    end
    foreach (runs[i]) due_results.push_back(runs[i]);
  endfunction

  function automatic in_t make_job(logic [15:0] id, logic [31:0] at, logic [15:0] bt,
                                   logic fin);
    in_t job;
    job.job_id = id;
    job.arrival_time = at;
    job.burst_length = bt;
    job.final_job = fin;
    return job;
  endfunction

  function automatic string result_text(out_t r);
    return $sformatf("id %h comp %h tat %h wait %h sum_tat %h sum_wait %h status %b last %b",
                     r.done_id, r.completion_time, r.turnaround, r.waiting,
                     r.sum_turnaround, r.sum_waiting, r.status, r.last_result);
  endfunction

  // Valid stays high from one request to the next unless a gap is drawn.
  task automatic send_job(input in_t job);
    int unsigned gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= job;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    schedule_job(job);
    jobs_sent++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic send_batch(input int unsigned len, input traffic_mix_e mix);
    in_t         job;
    logic [32:0] at;
    int unsigned step;
    if (mix == MIX_WIDE) at = {1'b0, $urandom()};
    else if ($urandom_range(0, 9) == 0) at = {1'b0, TIME_MAX - $urandom_range(0, 200000)};
    else at = 33'($urandom_range(0, 5000));
    for (int unsigned i = 0; i < len; i++) begin
      case (mix)
        MIX_CONGESTED: begin
          step = $urandom_range(0, 40);
          job.burst_length = 16'($urandom_range(0, 300));
        end
        MIX_LIGHT: begin
          step = $urandom_range(0, 200);
          job.burst_length = 16'($urandom_range(0, 50));
        end
        MIX_WIDE: begin
          step = $urandom_range(0, 65535);
          job.burst_length = 16'($urandom());
        end
        default: begin
          step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20000) : 0;
          job.burst_length = 16'($urandom_range(0, 5000));
        end
      endcase
      at = at + 33'(step);
      if (at[32]) at = {1'b0, TIME_MAX};
      job.job_id = 16'($urandom());
      // A few arrivals ignore the batch order and may land behind time.
      job.arrival_time = ($urandom_range(0, 19) == 0) ? $urandom() : at[31:0];
      job.final_job = (i == len - 1);
      send_job(job);
    end
    batches_sent++;
  endtask

  task automatic test_directed();
    send_job(make_job(16'h0000, 32'd0, 16'h0000, 1'b0));
    send_job(make_job(16'hFFFF, 32'd0, 16'hFFFF, 1'b0));
    send_job(make_job(16'h0001, 32'd100, 16'd7, 1'b0));
    send_job(make_job(16'h0002, 32'h0002_0000, 16'd3, 1'b1));
    send_job(make_job(16'h0010, 32'd1000, 16'd50, 1'b0));
    send_job(make_job(16'h0011, 32'd1020, 16'd5, 1'b0));
    send_job(make_job(16'h0012, 32'd10, 16'd5, 1'b0));
    send_job(make_job(16'h0013, 32'd2000, 16'd1, 1'b1));
    wait_all_results();
  endtask

  // The first run caps at the top of time, so its waiting floors at zero.
  task automatic test_time_saturation();
    send_job(make_job(16'hA5A5, 32'hFFFF_FF00, 16'hFFFF, 1'b0));
    send_job(make_job(16'h5A5A, 32'hFFFF_FF01, 16'h1000, 1'b0));
    send_job(make_job(16'hC3C3, TIME_MAX, 16'h0001, 1'b1));
    wait_all_results();
  endtask

  task automatic test_full_stack();
    for (int i = 0; i < DEPTH; i++)
      send_job(make_job(16'(16'h0100 + i), 32'd0, 16'($urandom_range(0, 1000)), 1'b0));
    send_job(make_job(16'h01FE, 32'd0, 16'd9, 1'b0));
    send_job(make_job(16'h01FF, 32'd0, 16'd9, 1'b1));
    // A full stack emptied by one far arrival gives the longest result list.
    for (int i = 0; i < DEPTH; i++)
      send_job(make_job(16'(16'h0200 + i), 32'd10, 16'($urandom_range(0, 60000)), 1'b0));
    send_job(make_job(16'h02FF, TIME_MAX, 16'd4, 1'b1));
    wait_all_results();
  endtask

  task automatic test_backpressure();
    hold_requests <= hold_requests + 1;
    send_batch(30, MIX_CONGESTED);
    wait_all_results();
  endtask

  task automatic test_random();
    int unsigned start;
    start = jobs_sent;
    while (jobs_sent < start + RANDOM_JOBS) begin
      send_batch($urandom_range(1, 40), traffic_mix_e'($urandom_range(0, 3)));
      if ($urandom_range(0, 7) == 0) wait_all_results();
    end
    wait_all_results();
  endtask

  // Both sides run without a single idle cycle for one long batch.
  task automatic test_no_idle();
    no_idle = 1'b1;
    send_batch(NO_IDLE_JOBS, MIX_BURSTY);
    wait_all_results();
    no_idle = 1'b0;
  endtask

  initial begin
    int unsigned hold_left;
    int unsigned holds_done;
    hold_left = 0;
    holds_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : check_result
    out_t  want;
    string diff;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.status == STATUS_DROP) drops_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", result_text(out_data));
      end else begin
        want = due_results.pop_front();
        diff = "";
        if (out_data.done_id !== want.done_id) diff = {diff, " done_id"};
        if (out_data.completion_time !== want.completion_time) diff = {diff, " completion_time"};
        if (out_data.turnaround !== want.turnaround) diff = {diff, " turnaround"};
        if (out_data.waiting !== want.waiting) diff = {diff, " waiting"};
        if (out_data.sum_turnaround !== want.sum_turnaround) diff = {diff, " sum_turnaround"};
        if (out_data.sum_waiting !== want.sum_waiting) diff = {diff, " sum_waiting"};
        if (out_data.status !== want.status) diff = {diff, " status"};
        if (out_data.last_result !== want.last_result) diff = {diff, " last_result"};
        if (diff != "") begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch in%s", diff);
            $display("  expected %s", result_text(want));
            $display("  actual   %s", result_text(out_data));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("no request or result moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_time_saturation();
    test_full_stack();
    test_backpressure();
    test_random();
    test_no_idle();
    wait_all_results();
    repeat (20) @(posedge clk);
    $display("%0d jobs in %0d random batches plus directed ones, %0d results, %0d drops",
             jobs_sent, batches_sent, results_seen, drops_seen);
    $display("full stack, capped time, late arrivals, long stall, gap-free run: %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
